// ===== src/ropg_pkg.sv =====
package ropg_pkg;

  // Width of an item number and of the element count
  localparam int unsigned ItemW = 8;
  // Cells examined past the current one when looking for the next pair
  localparam int unsigned LOOKAHEAD = 3;

  // Table geometry derived from the element count
  typedef struct packed {
    logic [ItemW-1:0] w;     // odd working size
    logic [ItemW-1:0] rows;  // (w+1)/2
    logic [ItemW-1:0] cols;  // w-1
    logic             pad;   // element count is even, cells holding w are dropped
  } geom_t;

  // Table position; one spare column bit so a lookahead step past the end cannot wrap
  typedef struct packed {
    logic [ItemW:0]   col;
    logic [ItemW-1:0] row;
  } pos_t;

  // Pair held in one cell
  typedef struct packed {
    logic             valid;
    logic [ItemW-1:0] first;
    logic [ItemW-1:0] second;
  } pair_t;

  localparam geom_t GeomReset = '{w: 8'd3, rows: 8'd2, cols: 8'd2, pad: 1'b1};
  localparam pos_t  PosStart  = '{col: 9'd1, row: 8'd1};

  // Geometry for a count already saturated into 2..255
  function automatic geom_t make_geom(logic [ItemW-1:0] n);
    geom_t g;
    g.w    = n | 8'd1;
    g.rows = 8'(g.w >> 1) + 8'd1;
    g.cols = g.w - 8'd1;
    g.pad  = ~n[0];
    return g;
  endfunction

  // Next cell in walk order: down the column, then top of the next column
  function automatic pos_t step_pos(pos_t p, geom_t g);
    pos_t s;
    if (p.row >= g.rows) begin
      s.col = p.col + 9'd1;
      s.row = 8'd1;
    end else begin
      s.col = p.col;
      s.row = p.row + 8'd1;
    end
    return s;
  endfunction

endpackage

// ===== src/ropg_cell.sv =====
module ropg_cell import ropg_pkg::*; (
  input  geom_t geom_i,
  input  pos_t  pos_i,
  output pair_t pair_o
);

  logic [9:0]        c, r, w, rows, cols, k, q, p, x, y;
  logic signed [10:0] f;
  logic              odd, in_range, skip, has_w;

  // Pair rules for first, last and middle rows
  always_comb begin
    c    = {1'b0, pos_i.col};
    r    = {2'b0, pos_i.row};
    w    = {2'b0, geom_i.w};
    rows = {2'b0, geom_i.rows};
    cols = {2'b0, geom_i.cols};
    odd  = pos_i.col[0];

    in_range = (c != 10'd0) && (c <= cols) && (r != 10'd0) && (r <= rows);

    // k = (oc+1)/2 with oc the odd column at or left of c
    k = odd ? ((c + 10'd1) >> 1) : (c >> 1);
    f = $signed({1'b0, k}) - $signed({1'b0, r}) + 11'sd2;
    p = (f > 11'sd1) ? f[9:0] : (w - 10'd1 + f[9:0]);
    q = k + r;

    skip = 1'b0;
    if (r == 10'd1) begin
      if (odd) begin
        x = 10'd1;
        y = (c + 10'd3) >> 1;
      end else begin
        y = (c + 10'd2) >> 1;
        x = y + 10'd1;
      end
    end else if (r == rows) begin
      x    = rows + ((c + 10'd1) >> 1);
      y    = 10'd1;
      skip = ~odd;
    end else begin
      if (odd) begin
        x = p;
        y = q;
      end else begin
        x = q + 10'd1;
        y = p;
      end
    end

    // padding item never appears in a pair
    has_w = geom_i.pad && ((x == w) || (y == w));

    pair_o.valid = in_range && !skip && !has_w;
    // last column is presented swapped
    if (c == cols) begin
      pair_o.first  = y[ItemW-1:0];
      pair_o.second = x[ItemW-1:0];
    end else begin
      pair_o.first  = x[ItemW-1:0];
      pair_o.second = y[ItemW-1:0];
    end
  end

endmodule

// ===== src/ropg_seek.sv =====
module ropg_seek import ropg_pkg::*; (
  input  geom_t geom_i,
  input  pos_t  cur_i,
  output pair_t cur_pair_o,
  output pos_t  next_o,
  output logic  next_found_o
);

  pos_t  cand [LOOKAHEAD+1];
  pair_t pair [LOOKAHEAD+1];

  // Candidate cells: the current one and the few that follow it
  always_comb begin
    cand[0] = cur_i;
    for (int i = 1; i <= int'(LOOKAHEAD); i++) begin
      cand[i] = step_pos(cand[i-1], geom_i);
    end
  end

  for (genvar g = 0; g <= LOOKAHEAD; g++) begin : g_cell
    ropg_cell u_cell (
      .geom_i (geom_i),
      .pos_i  (cand[g]),
      .pair_o (pair[g])
    );
  end

  assign cur_pair_o = pair[0];

  // Earliest candidate after the current one that holds a pair
  always_comb begin
    next_o       = cand[LOOKAHEAD];
    next_found_o = 1'b0;
    for (int i = int'(LOOKAHEAD); i >= 1; i--) begin
      if (pair[i].valid) begin
        next_o       = cand[i];
        next_found_o = 1'b1;
      end
    end
  end

endmodule

// ===== src/ross_pair_order_generator.sv =====
// Emits every unordered pair of items 1..N in balanced paired-comparison order,
// one pair per accepted request word; restart_i = 1 rewinds to the first pair first.
// For each request, the pair of the current table cell and the
// position of the next cell holding a pair come from one pass of combinational
// logic over the position register and a three-cell lookahead, and the pair is
// held in an output register, so a new request is taken every cycle while the
// output side keeps up. After the pair flagged last_pair_o, requests produce
// no word until a restart. Writing element_count_i (saturated to
// 2..MAX_ELEMENTS) also rewinds the walk; write only while the block is idle.
module ross_pair_order_generator import ropg_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             element_count_we_i,
  input  logic [ItemW-1:0] element_count_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ItemW-1:0] first_item_o,
  output logic [ItemW-1:0] second_item_o,
  output logic             last_pair_o
);

  localparam logic [ItemW-1:0] MaxCount = ItemW'(MAX_ELEMENTS);
  localparam logic [ItemW-1:0] MinCount = 8'd2;

  geom_t            geom_q, geom_d;
  pos_t             pos_q, pos_d, cur_pos, next_pos;
  logic             done_q, done_d, cur_done;
  pair_t            cur_pair;
  logic             next_found, in_acc, emit;
  logic [ItemW-1:0] count_sat;
  logic             out_valid_q, out_valid_d, last_q;
  logic [ItemW-1:0] first_q, second_q;

  // Saturate the written count
  always_comb begin
    if (element_count_i < MinCount) begin
      count_sat = MinCount;
    end else if (element_count_i > MaxCount) begin
      count_sat = MaxCount;
    end else begin
      count_sat = element_count_i;
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Position seen by this request word
  assign cur_pos  = restart_i ? PosStart : pos_q;
  assign cur_done = restart_i ? 1'b0 : done_q;

  ropg_seek u_seek (
    .geom_i       (geom_q),
    .cur_i        (cur_pos),
    .cur_pair_o   (cur_pair),
    .next_o       (next_pos),
    .next_found_o (next_found)
  );

  assign emit = in_acc && !cur_done && cur_pair.valid;

  // Walk state update
  always_comb begin
    geom_d = geom_q;
    pos_d  = pos_q;
    done_d = done_q;
    if (element_count_we_i) begin
      geom_d = make_geom(count_sat);
      pos_d  = PosStart;
      done_d = 1'b0;
    end else if (in_acc) begin
      pos_d  = cur_pos;
      done_d = cur_done;
      if (!cur_done) begin
        if (cur_pair.valid && next_found) begin
          pos_d = next_pos;
        end else begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q <= GeomReset;
      pos_q  <= PosStart;
      done_q <= 1'b0;
    end else begin
      geom_q <= geom_d;
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  // Output word register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      first_q  <= cur_pair.first;
      second_q <= cur_pair.second;
      last_q   <= !next_found;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign first_item_o  = first_q;
  assign second_item_o = second_q;
  assign last_pair_o   = last_q;

  // The final pair leaves the walk finished
  a_last_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !next_found && !element_count_we_i) |=> done_q)
    else $error("final pair did not end the walk");

  // An unfinished walk always sits on a cell inside the table
  a_pos_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_q |-> (pos_q.row >= 8'd1 && pos_q.row <= geom_q.rows &&
                 pos_q.col >= 9'd1 && pos_q.col <= {1'b0, geom_q.cols}))
    else $error("walk position outside the table");

  // The stored position always holds a pair while the walk is running
  a_cur_cell_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cur_done) |-> cur_pair.valid)
    else $error("walk position holds no pair");

  // A pair never compares an item with itself
  a_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (first_q != second_q))
    else $error("pair repeats one item");

endmodule
